// ===== rtl/rmpg_pkg.sv =====
// Shared types, constants and functions for the ring moire pixel generator.
package rmpg_pkg;

	localparam int DX_W = 9;
	localparam int DY_W = 8;
	localparam int DXSQ_W = 2 * DX_W;
	localparam int DYSQ_W = 2 * DY_W;
	localparam int D2_W = DXSQ_W + 1;
	localparam int NUM_BANDS = 18;
	localparam int BAND_WIDTH = 16;
	localparam int ROWS = 8;

	typedef logic [DX_W-1:0] dx_t;
	typedef logic [DY_W-1:0] dy_t;
	typedef logic [D2_W-1:0] d2_t;
	typedef logic [7:0] byte_t;

	// The ring value reaches BAND_WIDTH*j exactly when d2 exceeds this bound.
	function automatic d2_t band_bound(input int j);
		int t;
		t = BAND_WIDTH * j - 1;
		return D2_W'(t * t + 1);
	endfunction

	function automatic byte_t logo_byte(input logic [4:0] idx);
		byte_t b;
		case (idx)
			5'd0: b = 8'd62;
			5'd1: b = 8'd65;
			5'd2: b = 8'd73;
			5'd3: b = 8'd73;
			5'd4: b = 8'd121;
			5'd5: b = 8'd0;
			5'd6: b = 8'd127;
			5'd7: b = 8'd64;
			5'd8: b = 8'd64;
			5'd9: b = 8'd64;
			5'd10: b = 8'd64;
			default: b = 8'd0;
		endcase
		return b;
	endfunction

endpackage

// ===== rtl/rmpg_ring.sv =====
// Ring classification of one squared distance: parity of the band crossings.
module rmpg_ring import rmpg_pkg::*; (
	input  d2_t  d2,
	output logic ring
);

	logic [NUM_BANDS-1:0] above;

	always_comb begin
		for (int j = 0; j < NUM_BANDS; j++) begin
			above[j] = d2 > band_bound(j + 1);
		end
	end

	// Thresholds rise, so the crossings form a run and their parity is the band parity.
	assign ring = ~(^above);

endmodule

// ===== rtl/ring_moire_pixel_generator_unit.sv =====
// Top level of the ring moire pixel generator: four-stage pipeline.
// Throughput: one transaction per cycle; a full stage holds while the next stage holds.
// The squared distances and band compares of sixteen ring points set the stage split.
// Reset clears the stage valid bits only; the payload registers are not reset.
module ring_moire_pixel_generator_unit import rmpg_pkg::*; #(
	parameter int DISPLAY_COLUMNS = 120,
	parameter int DISPLAY_PAGES = 8,
	parameter int FIELD_WIDTH = 240,
	parameter int FIELD_HEIGHT = 128,
	parameter int LOGO_LENGTH = 12
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [6:0] column,
	input  logic [2:0] page,
	input  logic [6:0] first_offset_x,
	input  logic [5:0] first_offset_y,
	input  logic [6:0] second_offset_x,
	input  logic [5:0] second_offset_y,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] pixel_byte
);

	localparam logic signed [10:0] CX = 11'(FIELD_WIDTH / 2);
	localparam logic signed [9:0] CY = 10'(FIELD_HEIGHT / 2);
	localparam logic [8:0] LOGO_START = 9'(DISPLAY_COLUMNS - LOGO_LENGTH);
	localparam logic [8:0] LOGO_LEN = 9'(LOGO_LENGTH);
	localparam logic [3:0] LAST_PAGE = 4'(DISPLAY_PAGES - 1);

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	assign en4 = !v_s4 || !out_stall;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_stall = !en1;
	assign out_valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// Stage 1: distances from the field centre and the logo byte.
	dx_t   dx_c [2];
	dy_t   dy_c [2][ROWS];
	byte_t logo_c;
	logic [8:0] col9;
	logic [8:0] logo_off;

	always_comb begin
		logic [6:0] ox [2];
		logic [5:0] oy [2];
		logic signed [10:0] sx;
		logic signed [9:0] sy;
		ox[0] = first_offset_x;
		ox[1] = second_offset_x;
		oy[0] = first_offset_y;
		oy[1] = second_offset_y;
		for (int n = 0; n < 2; n++) begin
			sx = signed'({3'b000, 8'({1'b0, column} + {1'b0, ox[n]})}) - CX;
			dx_c[n] = DX_W'(sx < 0 ? -sx : sx);
			for (int k = 0; k < ROWS; k++) begin
				sy = signed'({3'b000, 7'({1'b0, page, 3'(k)} + {1'b0, oy[n]})}) - CY;
				dy_c[n][k] = DY_W'(sy < 0 ? -sy : sy);
			end
		end
	end

	assign col9 = {2'b00, column};
	// The offset wraps at nine bits, so a logo start left of column zero still works.
	assign logo_off = col9 - LOGO_START;

	always_comb begin
		logo_c = '0;
		if ({1'b0, page} == LAST_PAGE && logo_off < LOGO_LEN) begin
			logo_c = logo_byte(logo_off[4:0]);
		end
	end

	dx_t   dx_s1 [2];
	dy_t   dy_s1 [2][ROWS];
	byte_t logo_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			dx_s1 <= dx_c;
			dy_s1 <= dy_c;
			logo_s1 <= logo_c;
		end
	end

	// Stage 2: squares.
	logic [DXSQ_W-1:0] dxsq_s2 [2];
	logic [DYSQ_W-1:0] dysq_s2 [2][ROWS];
	byte_t logo_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			for (int n = 0; n < 2; n++) begin
				dxsq_s2[n] <= dx_s1[n] * dx_s1[n];
				for (int k = 0; k < ROWS; k++) begin
					dysq_s2[n][k] <= dy_s1[n][k] * dy_s1[n][k];
				end
			end
			logo_s2 <= logo_s1;
		end
	end

	// Stage 3: squared distances.
	d2_t   d2_s3 [2][ROWS];
	byte_t logo_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			for (int n = 0; n < 2; n++) begin
				for (int k = 0; k < ROWS; k++) begin
					d2_s3[n][k] <= D2_W'(dxsq_s2[n]) + D2_W'(dysq_s2[n][k]);
				end
			end
			logo_s3 <= logo_s2;
		end
	end

	// Stage 4: band parity per ring point, layers combined by XNOR, logo applied by XOR.
	logic  ring_c [2][ROWS];
	byte_t byte_c;
	byte_t pixel_byte_s4;

	for (genvar n = 0; n < 2; n++) begin : g_layer
		for (genvar k = 0; k < ROWS; k++) begin : g_row
			rmpg_ring u_ring (
				.d2   (d2_s3[n][k]),
				.ring (ring_c[n][k])
			);
		end
	end

	always_comb begin
		for (int k = 0; k < ROWS; k++) begin
			byte_c[k] = ~(ring_c[0][k] ^ ring_c[1][k]) ^ logo_s3[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			pixel_byte_s4 <= byte_c;
		end
	end

	assign pixel_byte = pixel_byte_s4;

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && v_s4))
		else $error("input stalled while a stage is empty");
	a_s2_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(en2 && v_s1) |=> v_s2)
		else $error("transaction lost between stage 1 and stage 2");
	a_s4_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(en4 && v_s3) |=> v_s4)
		else $error("transaction lost between stage 3 and stage 4");

endmodule

// ===== verif/rmpg_checker.sv =====
// Checker for the ring moire pixel generator: predicts each byte and compares it.
module rmpg_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [6:0] column,
	input  logic [2:0] page,
	input  logic [6:0] first_offset_x,
	input  logic [5:0] first_offset_y,
	input  logic [6:0] second_offset_x,
	input  logic [5:0] second_offset_y,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] pixel_byte,
	output int         failures,
	output int         pending
);
	localparam int CENTRE_X = 120;
	localparam int CENTRE_Y = 64;
	localparam int LOGO_FIRST = 108;
	localparam int LAST_COLUMN = 119;
	localparam int LAST_PAGE = 7;
	localparam logic [7:0] LOGO [12] = '{8'd62, 8'd65, 8'd73, 8'd73, 8'd121, 8'd0,
		8'd127, 8'd64, 8'd64, 8'd64, 8'd64, 8'd0};

	logic [7:0] expected_bytes[$];

	// Smallest r with r*r >= n, by a plain upward search.
	function automatic int ceil_root(input int n);
		int r;
		r = 0;
		while (r * r < n)
			r++;
		return r;
	endfunction

	function automatic logic in_light_band(input int fx, input int fy);
		int d2;
		int r;
		d2 = (fx - CENTRE_X) * (fx - CENTRE_X) + (fy - CENTRE_Y) * (fy - CENTRE_Y);
		r = (d2 == 0) ? 0 : ceil_root(d2 - 1);
		return (r % 32) < 16;
	endfunction

	function automatic logic [7:0] moire_byte(input int col, input int pg, input int ox1,
			input int oy1, input int ox2, input int oy2);
		logic [7:0] b;
		int row;
		for (int k = 0; k < 8; k++) begin
			row = 8 * pg + k;
			b[k] = ~(in_light_band(col + ox1, row + oy1) ^ in_light_band(col + ox2, row + oy2));
		end
		if (pg == LAST_PAGE && col >= LOGO_FIRST && col <= LAST_COLUMN)
			b ^= LOGO[col - LOGO_FIRST];
		return b;
	endfunction

	assign pending = expected_bytes.size();

	always @(posedge clk or negedge arst_n) begin
		logic [7:0] want;
		if (!arst_n) begin
			failures <= 0;
		end else begin
			if (in_valid && !in_stall)
				expected_bytes.push_back(moire_byte(column, page, first_offset_x, first_offset_y,
					second_offset_x, second_offset_y));
			if (out_valid && !out_stall) begin
				if (expected_bytes.size() == 0) begin
					if (failures < 10)
						$display("unexpected output transaction: pixel_byte %h", pixel_byte);
					failures <= failures + 1;
				end else begin
					want = expected_bytes.pop_front();
					if (want !== pixel_byte) begin
						if (failures < 10)
							$display("pixel_byte mismatch: expected %h, got %h", want, pixel_byte);
						failures <= failures + 1;
					end
				end
			end
		end
	end
endmodule

// ===== verif/tb.sv =====
// Testbench top for the ring moire pixel generator: stimulus, stalls and verdict.
module tb;
	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [6:0] column = 0;
	logic [2:0] page = 0;
	logic [6:0] first_offset_x = 0;
	logic [5:0] first_offset_y = 0;
	logic [6:0] second_offset_x = 0;
	logic [5:0] second_offset_y = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [7:0] pixel_byte;
	int failures;
	int pending;
	int cycles = 0;
	bit long_hold = 0;

	localparam int RANDOM_ITEMS = 1950;
	localparam int CYCLE_LIMIT = 400000;

	always #5 clk = ~clk;

	ring_moire_pixel_generator_unit DUT (.*);

	rmpg_checker checker_i (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic int gap_length();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
	endfunction

	// Receiver stalls; one long hold-off early on lets the pipeline fill up.
	initial begin
		int n;
		@(posedge arst_n);
		repeat (30) @(posedge clk);
		long_hold = 1;
		out_stall <= 1;
		repeat (60) @(posedge clk);
		long_hold = 0;
		forever begin
			n = gap_length();
			if ($urandom_range(0, 3) == 0)
				n = 0;
			out_stall <= (n != 0);
			repeat (n == 0 ? $urandom_range(1, 20) : n) @(posedge clk);
		end
	end

	task automatic offer(input logic [6:0] c, input logic [2:0] p, input logic [6:0] x1,
			input logic [5:0] y1, input logic [6:0] x2, input logic [5:0] y2);
		int n;
		column <= c;
		page <= p;
		first_offset_x <= x1;
		first_offset_y <= y1;
		second_offset_x <= x2;
		second_offset_y <= y2;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
		n = ($urandom_range(0, 2) == 0) ? gap_length() : 0;
		if (n > 0) begin
			in_valid <= 0;
			repeat (n) @(posedge clk);
		end
	endtask

	initial begin
		int wait_cycles;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Field extremes, full-range fields, the logo columns and around them.
		offer(0, 0, 0, 0, 0, 0);
		offer(119, 7, 120, 63, 120, 63);
		offer(127, 7, 127, 63, 127, 63);
		offer(120, 0, 0, 0, 120, 63);
		offer(0, 7, 120, 0, 0, 63);
		offer(60, 3, 60, 32, 60, 32);
		offer(107, 7, 5, 9, 77, 40);
		offer(108, 7, 5, 9, 77, 40);
		offer(113, 7, 5, 9, 77, 40);
		offer(119, 7, 5, 9, 77, 40);
		offer(120, 7, 5, 9, 77, 40);
		offer(127, 6, 127, 63, 0, 0);
		offer(108, 6, 1, 2, 3, 4);
		for (int c = 108; c <= 119; c++)
			offer(c[6:0], 7, 0, 0, 120, 63);
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if ($urandom_range(0, 9) == 0)
				offer(7'($urandom), 3'($urandom), 7'($urandom), 6'($urandom),
					7'($urandom), 6'($urandom));
			else
				offer(7'($urandom_range(0, 119)), 3'($urandom),
					7'($urandom_range(0, 120)), 6'($urandom),
					7'($urandom_range(0, 120)), 6'($urandom));
		end
		in_valid <= 0;
		while (pending != 0 || long_hold) @(posedge clk);
		wait_cycles = 0;
		while (wait_cycles < 20) begin
			@(posedge clk);
			wait_cycles++;
		end
		if (failures == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/rmpg_pkg.sv
rtl/rmpg_ring.sv
rtl/ring_moire_pixel_generator_unit.sv
verif/rmpg_checker.sv
verif/tb.sv
